// ----- rtl/line_pixel_color_gradient_assert.svh -----
// assertion macros used by the bound checker lpcg_checker
`ifndef LINE_PIXEL_COLOR_GRADIENT_ASSERT_SVH
`define LINE_PIXEL_COLOR_GRADIENT_ASSERT_SVH

// same-cycle implication
`define LPCG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define LPCG_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

// ----- rtl/lpcg_pkg.sv -----
`timescale 1ns / 1ps
package lpcg_pkg;
	localparam int COORD_BITS      = 16;
	localparam int RATIO_FRAC_BITS = 16;

	localparam int RGB_W   = 24;
	localparam int LEN_W   = 25;
	localparam int DIST_FRAC_SHIFT = 16;   // 8 fraction bits on the root
	localparam int D_W     = COORD_BITS + 1;
	localparam int SQ_W    = 2 * D_W;
	localparam int SUM_W   = SQ_W + 1;
	localparam int RAD_W   = SUM_W + DIST_FRAC_SHIFT;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int RADP_W  = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int CMP_W   = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;
	localparam int R_W     = RATIO_FRAC_BITS + 1;
	localparam int PROD_W  = 8 + R_W;
	localparam int LATENCY = 5 + ROOT_W + RATIO_FRAC_BITS;

	localparam int ADDR_W  = 3;
	localparam logic [ADDR_W-3:0] REG_IDX_PROFILE = '0;

	localparam logic [1:0] PROF_PLAIN  = 2'd0;
	localparam logic [1:0] PROF_YELLOW = 2'd1;
	localparam logic [1:0] PROF_FLAT   = 2'd2;
	localparam logic [1:0] PROF_SPARE  = 2'd3;   // unused code, acts as the yellow profile

	localparam logic [RGB_W-1:0] WHITE_RGB  = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] YELLOW_RGB = 24'hFFFF00;

	typedef struct packed {
		logic             flat;
		logic             zero_len;
		logic [RGB_W-1:0] c1;
		logic [RGB_W-1:0] c2;
		logic [LEN_W-1:0] len;
	} ctx_t;
endpackage

// ----- rtl/line_pixel_color_gradient.sv -----
`timescale 1ns / 1ps
// throughput: one request per cycle, set by the fully pipelined square root and divider
// busy is always low; the result receiver cannot stall and never needs to
// reset: arst_n clears the profile register to plain gradient and all stage valid bits
module line_pixel_color_gradient (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0]   start_x,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0]   start_y,
	input  logic        [lpcg_pkg::RGB_W-1:0]        start_color,
	input  logic        [lpcg_pkg::RGB_W-1:0]        end_color,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0]   point_x,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0]   point_y,
	input  logic        [lpcg_pkg::LEN_W-1:0]        line_length,
	output logic                                     done,
	output logic        [lpcg_pkg::RGB_W-1:0]        pixel_rgb,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic        [lpcg_pkg::ADDR_W-1:0]       paddr,
	input  logic        [31:0]                       pwdata,
	output logic        [31:0]                       prdata,
	output logic                                     pready
);
	localparam int CB = lpcg_pkg::COORD_BITS;
	localparam int F  = lpcg_pkg::RATIO_FRAC_BITS;
	localparam int RB = lpcg_pkg::ROOT_W;

	// config register
	logic [1:0] profile_q;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_hit = (paddr[lpcg_pkg::ADDR_W-1:2] == lpcg_pkg::REG_IDX_PROFILE);
	assign prdata  = reg_hit ? {30'd0, profile_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_q <= lpcg_pkg::PROF_PLAIN;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			profile_q <= pwdata[1:0];
		end
	end

	// stage 1: endpoint color substitution and absolute coordinate deltas
	logic signed [CB:0]            dx, dy;
	logic        [CB:0]            ux, uy;
	lpcg_pkg::ctx_t                ctx_in;
	logic                          vld_s1, vld_s2, vld_s3;
	logic        [CB:0]            ux_s1, uy_s1;
	lpcg_pkg::ctx_t                ctx_s1, ctx_s2, ctx_s3;

	assign dx = {point_x[CB-1], point_x} - {start_x[CB-1], start_x};
	assign dy = {point_y[CB-1], point_y} - {start_y[CB-1], start_y};
	assign ux = dx[CB] ? (-dx) : dx;
	assign uy = dy[CB] ? (-dy) : dy;

	always_comb begin
		ctx_in.flat     = (profile_q == lpcg_pkg::PROF_FLAT);
		ctx_in.zero_len = (line_length == '0);
		ctx_in.len      = line_length;
		ctx_in.c1       = start_color;
		ctx_in.c2       = end_color;
		if (ctx_in.flat) begin
			// flat color: the start color unless white, carried in c1
			ctx_in.c1 = (start_color == lpcg_pkg::WHITE_RGB) ? end_color : start_color;
		end else if (profile_q != lpcg_pkg::PROF_PLAIN) begin
			if (start_color == lpcg_pkg::WHITE_RGB) ctx_in.c1 = lpcg_pkg::YELLOW_RGB;
			if (end_color == lpcg_pkg::WHITE_RGB)   ctx_in.c2 = lpcg_pkg::YELLOW_RGB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 2: squares, stage 3: sum of squares
	logic [lpcg_pkg::SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [lpcg_pkg::SUM_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		ux_s1  <= ux;
		uy_s1  <= uy;
		ctx_s1 <= ctx_in;
		sqx_s2 <= ux_s1 * ux_s1;
		sqy_s2 <= uy_s1 * uy_s1;
		ctx_s2 <= ctx_s1;
		sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		ctx_s3 <= ctx_s2;
	end

	// square root, one result bit per stage: distance = floor(sqrt(sum * 2^16))
	logic                            sq_vld_s  [0:RB];
	logic [lpcg_pkg::RADP_W-1:0]     sq_rad_s  [0:RB];
	logic [lpcg_pkg::REM_W-1:0]      sq_rem_s  [0:RB];
	logic [RB-1:0]                   sq_root_s [0:RB];
	lpcg_pkg::ctx_t                  sq_ctx_s  [0:RB];

	assign sq_vld_s[0]  = vld_s3;
	assign sq_rad_s[0]  = {{(lpcg_pkg::RADP_W - lpcg_pkg::RAD_W){1'b0}}, sum_s3,
		{lpcg_pkg::DIST_FRAC_SHIFT{1'b0}}};
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_ctx_s[0]  = ctx_s3;

	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic [lpcg_pkg::REM_W-1:0] rem_sh, trial;
		logic                       fit;
		assign rem_sh = {sq_rem_s[k][lpcg_pkg::REM_W-3:0],
			sq_rad_s[k][lpcg_pkg::RADP_W-1 -: 2]};
		assign trial  = {1'b0, sq_root_s[k], 2'b01};
		assign fit    = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else         sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
			sq_rem_s[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
			sq_root_s[k+1] <= {sq_root_s[k][RB-2:0], fit};
			sq_ctx_s[k+1]  <= sq_ctx_s[k];
		end
	end

	// ratio: restoring divide of distance * 2^F by length, one quotient bit per stage
	logic [lpcg_pkg::CMP_W-1:0] dist_ext, len_ext;
	logic                       dv_vld_s [0:F];
	logic                       dv_sat_s [0:F];
	logic [lpcg_pkg::LEN_W-1:0] dv_rem_s [0:F];
	logic [F-1:0]               dv_q_s   [0:F];
	lpcg_pkg::ctx_t             dv_ctx_s [0:F];

	assign dist_ext    = lpcg_pkg::CMP_W'(sq_root_s[RB]);
	assign len_ext     = lpcg_pkg::CMP_W'(sq_ctx_s[RB].len);
	assign dv_vld_s[0] = sq_vld_s[RB];
	assign dv_sat_s[0] = (dist_ext >= len_ext);
	assign dv_rem_s[0] = dv_sat_s[0] ? '0 : dist_ext[lpcg_pkg::LEN_W-1:0];
	assign dv_q_s[0]   = '0;
	assign dv_ctx_s[0] = sq_ctx_s[RB];

	for (genvar k = 0; k < F; k++) begin : g_div
		logic [lpcg_pkg::LEN_W:0] rem_sh, rem_sub;
		logic                     fit;
		assign rem_sh  = {dv_rem_s[k], 1'b0};
		assign fit     = (rem_sh >= {1'b0, dv_ctx_s[k].len});
		assign rem_sub = rem_sh - {1'b0, dv_ctx_s[k].len};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k+1] <= 1'b0;
			else         dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			dv_rem_s[k+1] <= fit ? rem_sub[lpcg_pkg::LEN_W-1:0] : rem_sh[lpcg_pkg::LEN_W-1:0];
			dv_q_s[k+1]   <= {dv_q_s[k][F-2:0], fit};
			dv_sat_s[k+1] <= dv_sat_s[k];
			dv_ctx_s[k+1] <= dv_ctx_s[k];
		end
	end

	// blend stage: per channel products, then sum and drop fraction
	localparam logic [lpcg_pkg::R_W-1:0] ONE = lpcg_pkg::R_W'(1) << F;

	logic [lpcg_pkg::R_W-1:0]    ratio, ratio_inv;
	logic                        vld_bl, done_q;
	logic                        flat_bl;
	logic [lpcg_pkg::RGB_W-1:0]  flat_rgb_bl, pixel_rgb_q, blend_rgb;
	logic [lpcg_pkg::PROD_W-1:0] pa_bl [0:2];
	logic [lpcg_pkg::PROD_W-1:0] pb_bl [0:2];

	always_comb begin
		if (dv_ctx_s[F].zero_len) ratio = '0;
		else if (dv_sat_s[F])     ratio = ONE;
		else                      ratio = {1'b0, dv_q_s[F]};
	end
	assign ratio_inv = ONE - ratio;

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic [lpcg_pkg::PROD_W:0] mix;
		always_ff @(posedge clk) begin
			pa_bl[ch] <= {{(lpcg_pkg::PROD_W - 8){1'b0}}, dv_ctx_s[F].c1[8*ch +: 8]} *
				{{(lpcg_pkg::PROD_W - lpcg_pkg::R_W){1'b0}}, ratio_inv};
			pb_bl[ch] <= {{(lpcg_pkg::PROD_W - 8){1'b0}}, dv_ctx_s[F].c2[8*ch +: 8]} *
				{{(lpcg_pkg::PROD_W - lpcg_pkg::R_W){1'b0}}, ratio};
		end
		assign mix = {1'b0, pa_bl[ch]} + {1'b0, pb_bl[ch]};
		assign blend_rgb[8*ch +: 8] = mix[F +: 8];
	end

	always_ff @(posedge clk) begin
		flat_bl     <= dv_ctx_s[F].flat;
		flat_rgb_bl <= dv_ctx_s[F].c1;
		pixel_rgb_q <= flat_bl ? flat_rgb_bl : blend_rgb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_bl <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_bl <= dv_vld_s[F];
			done_q <= vld_bl;
		end
	end

	assign done      = done_q;
	assign pixel_rgb = pixel_rgb_q;
endmodule

// ----- rtl/lpcg_checker.sv -----
`timescale 1ns / 1ps
`include "line_pixel_color_gradient_assert.svh"
module lpcg_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);
	`LPCG_ASSERT_DELAY(a_req_done, clk, arst_n, start && !busy, lpcg_pkg::LATENCY, done, "request without result")
	`LPCG_ASSERT_IMPLY(a_done_req, clk, arst_n, done, $past(start && !busy, lpcg_pkg::LATENCY), "result without request")
	`LPCG_ASSERT_IMPLY(a_busy_low, clk, arst_n, 1'b1, !busy, "busy raised")
	`LPCG_ASSERT_IMPLY(a_pready, clk, arst_n, 1'b1, pready, "pready dropped")
endmodule

bind line_pixel_color_gradient lpcg_checker u_lpcg_checker (.*);

// ----- tb/line_pixel_color_gradient_checker.sv -----
`timescale 1ns / 1ps
module line_pixel_color_gradient_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic                                   busy,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0] start_x,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0] start_y,
	input  logic        [lpcg_pkg::RGB_W-1:0]      start_color,
	input  logic        [lpcg_pkg::RGB_W-1:0]      end_color,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0] point_x,
	input  logic signed [lpcg_pkg::COORD_BITS-1:0] point_y,
	input  logic        [lpcg_pkg::LEN_W-1:0]      line_length,
	input  logic                                   done,
	input  logic        [lpcg_pkg::RGB_W-1:0]      pixel_rgb,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic        [lpcg_pkg::ADDR_W-1:0]     paddr,
	input  logic        [31:0]                     pwdata,
	input  logic                                   pready,
	output int                                     fail_count,
	output int                                     pending
);
	import lpcg_pkg::*;

	logic [1:0]       profile;
	logic [RGB_W-1:0] rgb_expected[$];

	// exact floor(sqrt(dx^2 + dy^2) * 256), then blend per channel; the flat profile skips both
	function automatic logic [RGB_W-1:0] blend_pixel(
		input logic [1:0] prof,
		input logic signed [COORD_BITS-1:0] sx, sy, px, py,
		input logic [RGB_W-1:0] c1_in, c2_in,
		input logic [LEN_W-1:0] len);
		longint dx, dy;
		longint unsigned rad, root, cand, ratio, one, ca, cb, v;
		logic [RGB_W-1:0] c1, c2, res;
		c1 = c1_in;
		c2 = c2_in;
		if (prof == PROF_FLAT)
			return (c1 == WHITE_RGB) ? c2 : c1;
		if (prof != PROF_PLAIN) begin
			if (c1 == WHITE_RGB) c1 = YELLOW_RGB;
			if (c2 == WHITE_RGB) c2 = YELLOW_RGB;
		end
		one = 64'd1 << RATIO_FRAC_BITS;
		if (len == 0) begin
			ratio = 0;
		end else begin
			dx = longint'(px) - longint'(sx);
			dy = longint'(py) - longint'(sy);
			rad = longint'(dx * dx + dy * dy) << 16;
			root = 0;
			for (int b = 26; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				if (cand * cand <= rad) root = cand;
			end
			ratio = (root >= len) ? one : (root << RATIO_FRAC_BITS) / len;
		end
		res = '0;
		for (int sh = 0; sh <= 16; sh += 8) begin
			ca = (c1 >> sh) & 8'hFF;
			cb = (c2 >> sh) & 8'hFF;
			v = (ca * (one - ratio) + cb * ratio) >> RATIO_FRAC_BITS;
			res |= RGB_W'(v & 8'hFF) << sh;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile <= PROF_PLAIN;
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_IDX_PROFILE)
				profile <= pwdata[1:0];
			if (start && !busy)
				rgb_expected.push_back(blend_pixel(profile, start_x, start_y, point_x,
					point_y, start_color, end_color, line_length));
			if (done) begin
				if (rgb_expected.size() == 0)
					report_mismatch($sformatf("pixel_rgb %06h with no request pending",
						pixel_rgb));
				else if (rgb_expected[0] !== pixel_rgb)
					report_mismatch($sformatf("pixel_rgb %06h, expected %06h",
						pixel_rgb, rgb_expected.pop_front()));
				else
					void'(rgb_expected.pop_front());
			end
		end
		pending = rgb_expected.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
	end
endmodule

// ----- tb/line_pixel_color_gradient_tb.sv -----
`timescale 1ns / 1ps
module line_pixel_color_gradient_tb;
	import lpcg_pkg::*;

	// one pixel request as the block sees it
	typedef struct {
		logic signed [COORD_BITS-1:0] sx, sy, px, py;
		logic [RGB_W-1:0]             c1, c2;
		logic [LEN_W-1:0]             len;
	} pixel_req_t;

	logic clk, arst_n, start, busy, done, psel, penable, pwrite, pready;
	logic signed [COORD_BITS-1:0] start_x, start_y, point_x, point_y;
	logic [RGB_W-1:0]  start_color, end_color, pixel_rgb;
	logic [LEN_W-1:0]  line_length;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	logic              busy_seen;
	int                fail_count, pending;

	line_pixel_color_gradient i_dut (.*);

	line_pixel_color_gradient_checker i_checker (
		.clk, .arst_n, .start, .busy, .start_x, .start_y, .start_color, .end_color,
		.point_x, .point_y, .line_length, .done, .pixel_rgb, .psel, .penable, .pwrite,
		.paddr, .pwdata, .pready, .fail_count, .pending);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// busy only moves at rising edges; the falling edge gives a race-free copy
	always @(negedge clk) busy_seen = busy;

	// hold the request until an edge where busy was low
	task automatic send_pixel(input pixel_req_t r);
		start       <= 1'b1;
		start_x     <= r.sx;
		start_y     <= r.sy;
		point_x     <= r.px;
		point_y     <= r.py;
		start_color <= r.c1;
		end_color   <= r.c2;
		line_length <= r.len;
		@(posedge clk);
		while (busy_seen) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait out every pixel in flight, then the pipeline tail, before touching the register
	task automatic drain;
		idle_cycles(1);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// setup cycle, access cycle; pready is tied high so the write lands on the access edge
	task automatic write_profile(input logic [1:0] prof);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_IDX_PROFILE, 2'b00};
		pwdata  <= {30'd0, prof};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [RGB_W-1:0] rand_color;
		return ($urandom_range(7) == 0) ? WHITE_RGB : RGB_W'($urandom);
	endfunction

	// mostly pixels near the start with a length in a similar range, so ratios spread
	// over the whole [0, 1] span; some fully random points and zero lengths mixed in
	function automatic pixel_req_t rand_pixel;
		pixel_req_t r;
		int span, pick;
		span = $urandom_range(16, 1);
		pick = $urandom_range(19);
		r.sx = COORD_BITS'($urandom);
		r.sy = COORD_BITS'($urandom);
		r.c1 = rand_color();
		r.c2 = rand_color();
		if (pick < 3) begin
			r.px = COORD_BITS'($urandom);
			r.py = COORD_BITS'($urandom);
		end else begin
			r.px = r.sx + COORD_BITS'($urandom_range((1 << span) - 1));
			r.py = r.sy - COORD_BITS'($urandom_range((1 << span) - 1));
		end
		if (pick == 3)
			r.len = '0;
		else if (pick == 4)
			r.len = LEN_W'($urandom);
		else
			r.len = LEN_W'($urandom_range((1 << (span + 9)) - 1, 1));
		return r;
	endfunction

	pixel_req_t       directed[$];
	int               idle_pct[8] = '{0, 62, 0, 21, 62, 0, 21, 0};
	logic [1:0]       phase_profile[8] = '{PROF_PLAIN, PROF_YELLOW, PROF_FLAT, PROF_SPARE,
	                                       PROF_FLAT, PROF_YELLOW, PROF_PLAIN, PROF_SPARE};

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start_x     = '0;
		start_y     = '0;
		point_x     = '0;
		point_y     = '0;
		start_color = '0;
		end_color   = '0;
		line_length = '0;

		// extremes, white endpoints, zero length, pixel past the end, pixel on the start
		directed = '{
			'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 24'h123456, 24'hABCDEF, 25'd0},
			'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 24'h123456, 24'hABCDEF, 25'd256},
			'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'h000000, 24'hFFFFFF,
				25'h1FFFFFF},
			'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 24'hFFFFFF, 24'h000000,
				25'h1FFFFFF},
			'{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 24'hFF00FF, 24'h00FF00, 25'd1},
			'{16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'hFFFFFF, 24'h000000, 25'd2560},
			'{16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'h000000, 24'hFFFFFF, 25'd2560},
			'{16'sd0, 16'sd0, 16'sd3, 16'sd4, 24'hFFFFFF, 24'hFFFFFF, 25'd2560},
			'{16'sd10, 16'sd10, 16'sd13, 16'sd14, 24'h00FF00, 24'hFF0000, 25'd1280},
			'{16'sd10, 16'sd10, 16'sd100, 16'sd10, 24'h00FF00, 24'hFF0000, 25'd1280},
			'{16'sd5, -16'sd5, 16'sd6, -16'sd4, 24'h0000FF, 24'hFFFF00, 25'd363},
			'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 24'hFFFFFE, 24'h000001, 25'd256},
			'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 24'h808080, 24'h7F7F7F, 25'd255},
			'{16'sd0, 16'sd0, -16'sd1, -16'sd1, 24'hFFFFFF, 24'hFFFF00, 25'h1FFFFFF},
			'{16'sd100, 16'sd100, 16'sd100, 16'sd100, 24'hFFFFFF, 24'h123456, 25'd0},
			'{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 24'h555555, 24'hAAAAAA, 25'd512}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nonzero gradient profile, so white endpoints turn yellow in the directed set
		write_profile(PROF_YELLOW);
		foreach (directed[i]) send_pixel(directed[i]);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_profile(phase_profile[ph]);
			repeat (88) begin
				// each cycle is idle with the phase's odds, so that share of cycles is idle
				while ($urandom_range(99) < idle_pct[ph])
					idle_cycles(1);
				send_pixel(rand_pixel());
			end
			drain();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS line_pixel_color_gradient");
		else
			$display("FAIL line_pixel_color_gradient");
		$finish;
	end

	// generous ceiling on the whole run
	initial begin
		#2000000;
		$display("FAIL line_pixel_color_gradient");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/lpcg_pkg.sv
rtl/line_pixel_color_gradient.sv
rtl/lpcg_checker.sv
tb/line_pixel_color_gradient_checker.sv
tb/line_pixel_color_gradient_tb.sv
